/* sv/sphint_pkg.sv */
package sphint_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  localparam int SQRT_STEPS = WORD_BITS;
  localparam int DIV_STEPS = WORD_BITS - 1;
  localparam int LIM_LAT = 3 + SQRT_STEPS + DIV_STEPS;
  localparam int INTEG_LAT = 8;
  localparam int TOTAL_LAT = 1 + LIM_LAT + INTEG_LAT;

  localparam logic signed [31:0] WMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WMIN = 32'sh8000_0000;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

  localparam logic signed [31:0] MARGIN_XY = 32'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [31:0] MARGIN_Z = 32'(((64'd12 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_BOX_LENGTH = 3'd1;
  localparam logic [2:0] REG_BOX_WIDTH = 3'd2;
  localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
  localparam logic [2:0] REG_WALL_STIFFNESS = 3'd4;
  localparam logic [2:0] REG_WALL_DAMPING = 3'd5;
  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd6;
  localparam logic [2:0] REG_GRAVITY_Z = 3'd7;

  localparam logic [30:0] RST_TIME_STEP = 31'd16777;
  localparam logic [30:0] RST_BOX = 31'd16777216;
  localparam logic [30:0] RST_ACCEL_LIMIT = 31'h7fff_ffff;
  localparam logic signed [31:0] RST_GRAVITY_Z = -32'sd164416717;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] half_vel_x;
    logic signed [31:0] half_vel_y;
    logic signed [31:0] half_vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_half_vel_x;
    logic signed [31:0] new_half_vel_y;
    logic signed [31:0] new_half_vel_z;
  } result_t;

  typedef struct packed {
    logic lo_hit;
    logic hi_hit;
    logic signed [31:0] lo_force;
    logic signed [31:0] hi_force;
  } wall_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] half;
  } axis_t;

  function automatic logic signed [31:0] sat33(input logic [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? WMIN : WMAX;
    end
    return $signed(x[31:0]);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] r;
    logic neg;
    neg = a[31] ^ b[31];
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p = {32'd0, ma} * {32'd0, mb};
    r = (p + ROUND_HALF) >> FRAC_BITS;
    if (neg) begin
      if (r > 64'h8000_0000) begin
        return WMIN;
      end
      return $signed(32'(64'd0 - r));
    end
    if (r > 64'h7fff_ffff) begin
      return WMAX;
    end
    return $signed(r[31:0]);
  endfunction

endpackage

/* sv/sphint_limit.sv */
module sphint_limit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0][31:0]  acc,
  input  logic [30:0]       lim,
  output logic              out_valid,
  output logic [2:0][31:0]  acc_out
);

  localparam int NST = sphint_pkg::SQRT_STEPS + sphint_pkg::DIV_STEPS + 1;

  typedef struct packed {
    logic             over;
    logic [2:0][31:0] acc;
    logic [2:0][61:0] num;
    logic [63:0]      rad;
    logic [33:0]      srem;
    logic [31:0]      root;
    logic [2:0][31:0] drem;
    logic [2:0][30:0] quo;
  } lst_t;

  function automatic lst_t sqrt_step(input lst_t s);
    lst_t r;
    logic [35:0] rem;
    logic [35:0] trial;
    r = s;
    rem = {s.srem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (rem >= trial) begin
      r.srem = 34'(rem - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.srem = rem[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lst_t div_step(input lst_t s, input logic [2:0] nb);
    lst_t r;
    logic [32:0] r2;
    r = s;
    for (int i = 0; i < 3; i++) begin
      r2 = {s.drem[i], nb[i]};
      if (r2 >= {1'b0, s.root}) begin
        r.drem[i] = 32'(r2 - {1'b0, s.root});
        r.quo[i] = {s.quo[i][29:0], 1'b1};
      end else begin
        r.drem[i] = r2[31:0];
        r.quo[i] = {s.quo[i][29:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [2:0][31:0] a_mag;
  logic             a_valid;
  logic [2:0][31:0] a_acc;
  logic [2:0][63:0] a_sq;
  logic [63:0]      a_lsq;
  logic [2:0][61:0] a_num;
  lst_t             b_next;
  lst_t             st [NST];
  logic [NST-1:0]   st_valid;
  logic [2:0][31:0] sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = acc[i][31] ? 32'(-acc[i]) : acc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_acc <= acc;
    a_lsq <= {33'd0, lim} * {33'd0, lim};
    for (int i = 0; i < 3; i++) begin
      a_sq[i] <= {32'd0, a_mag[i]} * {32'd0, a_mag[i]};
      a_num[i] <= 62'({32'd0, a_mag[i]} * {33'd0, lim});
    end
  end

  always_comb begin
    b_next = '0;
    b_next.rad = a_sq[0] + a_sq[1] + a_sq[2];
    b_next.over = b_next.rad > a_lsq;
    b_next.acc = a_acc;
    b_next.num = a_num;
    for (int i = 0; i < 3; i++) begin
      b_next.drem[i] = {1'b0, a_num[i][61:31]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= a_valid;
    end
    st[0] <= b_next;
  end

  for (genvar g = 0; g < NST - 1; g++) begin : g_stage
    if (g < sphint_pkg::SQRT_STEPS) begin : g_sqrt
      always_ff @(posedge clk) begin
        st[g+1] <= sqrt_step(st[g]);
      end
    end else begin : g_div
      localparam int J = sphint_pkg::DIV_STEPS - 1 - (g - sphint_pkg::SQRT_STEPS);
      always_ff @(posedge clk) begin
        st[g+1] <= div_step(st[g], {st[g].num[2][J], st[g].num[1][J], st[g].num[0][J]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g+1] <= 1'b0;
      end else begin
        st_valid[g+1] <= st_valid[g];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st[NST-1].over) begin
        sel[i] = st[NST-1].acc[i][31] ? 32'(-{1'b0, st[NST-1].quo[i]})
                                      : {1'b0, st[NST-1].quo[i]};
      end else begin
        sel[i] = st[NST-1].acc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st_valid[NST-1];
    end
    acc_out <= sel;
  end

  a_limited: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(st[NST-1].over) |->
      ($signed(acc_out[0]) <= $signed({1'b0, lim})) &&
      ($signed(acc_out[0]) >= -$signed({1'b0, lim})) &&
      ($signed(acc_out[1]) <= $signed({1'b0, lim})) &&
      ($signed(acc_out[1]) >= -$signed({1'b0, lim})) &&
      ($signed(acc_out[2]) <= $signed({1'b0, lim})) &&
      ($signed(acc_out[2]) >= -$signed({1'b0, lim})))
    else $error("Limited acceleration exceeds the limit.");

endmodule

/* sv/sphint_walls.sv */
module sphint_walls (
  input  logic                    clk,
  input  logic signed [31:0]      pos,
  input  logic signed [31:0]      half_vel,
  input  logic [30:0]             len,
  input  logic signed [31:0]      margin,
  input  logic [30:0]             stiffness,
  input  logic [30:0]             damping,
  output sphint_pkg::wall_t       wall
);

  logic signed [31:0] d_lo;
  logic signed [31:0] d_hi;
  logic signed [31:0] h1;
  logic               hit_lo;
  logic               hit_hi;
  logic signed [31:0] k_lo;
  logic signed [31:0] k_hi;
  logic signed [31:0] c_h;

  always_ff @(posedge clk) begin
    d_lo <= sphint_pkg::sat_sub(margin, pos);
    d_hi <= sphint_pkg::sat_sub(margin, sphint_pkg::sat_sub($signed({1'b0, len}), pos));
    h1 <= half_vel;

    hit_lo <= !d_lo[31] && (d_lo != 32'sd0);
    hit_hi <= !d_hi[31] && (d_hi != 32'sd0);
    k_lo <= sphint_pkg::fx_mul($signed({1'b0, stiffness}), d_lo);
    k_hi <= sphint_pkg::fx_mul($signed({1'b0, stiffness}), d_hi);
    c_h <= sphint_pkg::fx_mul($signed({1'b0, damping}), h1);

    wall.lo_hit <= hit_lo;
    wall.hi_hit <= hit_hi;
    wall.lo_force <= sphint_pkg::sat_sub(k_lo, c_h);
    wall.hi_force <= sphint_pkg::sat_add(k_hi, c_h);
  end

endmodule

/* sv/sphint_integ.sv */
module sphint_integ (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [31:0]      acc,
  input  sphint_pkg::wall_t       wall,
  input  logic signed [31:0]      pos,
  input  logic signed [31:0]      vel,
  input  logic [30:0]             dt,
  input  logic [30:0]             len,
  input  logic signed [31:0]      grav,
  output logic                    out_valid,
  output sphint_pkg::axis_t       out
);

  logic [7:1] v;
  logic signed [31:0] s1_acc, s2_acc, s3_acc, s4_dv, s5_vel, s6_dp, s6_half, s7_pos;
  logic signed [31:0] s1_pos, s2_pos, s3_pos, s4_pos, s5_pos, s6_pos;
  logic signed [31:0] s1_vel, s2_vel, s3_vel, s4_vel, s5_vold, s6_vel, s7_vel, s7_half;
  logic               s1_hi_hit;
  logic signed [31:0] s1_hi_force;
  logic [32:0]        vsum;
  logic signed [31:0] top;
  logic signed [31:0] clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      v <= {v[6:1], in_valid};
      out_valid <= v[7];
    end
  end

  always_comb begin
    vsum = {s5_vel[31], s5_vel} + {s5_vold[31], s5_vold};
    top = sphint_pkg::sat_sub($signed({1'b0, len}), 32'sd1);
    clamped = (s7_pos < 32'sd1) ? 32'sd1 : s7_pos;
    if (clamped > top) begin
      clamped = top;
    end
  end

  always_ff @(posedge clk) begin
    s1_acc <= wall.lo_hit ? sphint_pkg::sat_add(acc, wall.lo_force) : acc;
    s1_hi_hit <= wall.hi_hit;
    s1_hi_force <= wall.hi_force;
    s1_pos <= pos;
    s1_vel <= vel;

    s2_acc <= s1_hi_hit ? sphint_pkg::sat_sub(s1_acc, s1_hi_force) : s1_acc;
    s2_pos <= s1_pos;
    s2_vel <= s1_vel;

    s3_acc <= sphint_pkg::sat_add(s2_acc, grav);
    s3_pos <= s2_pos;
    s3_vel <= s2_vel;

    s4_dv <= sphint_pkg::fx_mul($signed({1'b0, dt}), s3_acc);
    s4_pos <= s3_pos;
    s4_vel <= s3_vel;

    s5_vel <= sphint_pkg::sat_add(s4_vel, s4_dv);
    s5_vold <= s4_vel;
    s5_pos <= s4_pos;

    s6_half <= $signed(vsum[32:1]);
    s6_dp <= sphint_pkg::fx_mul(s5_vel, $signed({1'b0, dt}));
    s6_vel <= s5_vel;
    s6_pos <= s5_pos;

    s7_pos <= sphint_pkg::sat_add(s6_pos, s6_dp);
    s7_vel <= s6_vel;
    s7_half <= s6_half;

    out.pos <= clamped;
    out.vel <= s7_vel;
    out.half <= s7_half;
  end

  a_in_box: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out.pos <= $past(top)))
    else $error("Position left the box.");

endmodule

/* sv/sph_particle_integrate_step_top.sv */
// done is high in the same cycle in which result holds the new values for that item.
// Throughput: one item per cycle; the path is a fixed pipeline set by the 32-step square
// root and the 31-step division of the acceleration limit.
// busy is high only during reset, and the receiver cannot stall the results.
// Reset clears all valid bits and returns every configuration register to its documented default.
module sph_particle_integrate_step_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sphint_pkg::item_t    item,
  output logic                 done,
  output sphint_pkg::result_t  result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int LAT = sphint_pkg::LIM_LAT;

  logic [30:0]        time_step, box_length, box_width, box_height;
  logic [30:0]        wall_stiffness, wall_damping, accel_limit;
  logic signed [31:0] gravity_z;

  logic               in_v;
  sphint_pkg::item_t  in_q;
  sphint_pkg::item_t  dly [LAT];
  logic               lim_valid;
  logic [2:0][31:0]   lim_acc;
  sphint_pkg::wall_t  wall_x, wall_y, wall_z;
  sphint_pkg::axis_t  res_x, res_y, res_z;
  logic               done_y, done_z;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= sphint_pkg::RST_TIME_STEP;
      box_length <= sphint_pkg::RST_BOX;
      box_width <= sphint_pkg::RST_BOX;
      box_height <= sphint_pkg::RST_BOX;
      wall_stiffness <= '0;
      wall_damping <= '0;
      accel_limit <= sphint_pkg::RST_ACCEL_LIMIT;
      gravity_z <= sphint_pkg::RST_GRAVITY_Z;
    end else if (cfg_we) begin
      case (cfg_index)
        sphint_pkg::REG_TIME_STEP: time_step <= cfg_data[30:0];
        sphint_pkg::REG_BOX_LENGTH: box_length <= cfg_data[30:0];
        sphint_pkg::REG_BOX_WIDTH: box_width <= cfg_data[30:0];
        sphint_pkg::REG_BOX_HEIGHT: box_height <= cfg_data[30:0];
        sphint_pkg::REG_WALL_STIFFNESS: wall_stiffness <= cfg_data[30:0];
        sphint_pkg::REG_WALL_DAMPING: wall_damping <= cfg_data[30:0];
        sphint_pkg::REG_ACCEL_LIMIT: accel_limit <= cfg_data[30:0];
        sphint_pkg::REG_GRAVITY_Z: gravity_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_q <= item;
    dly[0] <= in_q;
    for (int i = 1; i < LAT; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  sphint_limit u_limit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v),
    .acc       ({in_q.acc_z, in_q.acc_y, in_q.acc_x}),
    .lim       (accel_limit),
    .out_valid (lim_valid),
    .acc_out   (lim_acc)
  );

  sphint_walls u_walls_x (
    .clk (clk), .pos (dly[LAT-4].pos_x), .half_vel (dly[LAT-4].half_vel_x),
    .len (box_length), .margin (sphint_pkg::MARGIN_XY),
    .stiffness (wall_stiffness), .damping (wall_damping), .wall (wall_x)
  );

  sphint_walls u_walls_y (
    .clk (clk), .pos (dly[LAT-4].pos_y), .half_vel (dly[LAT-4].half_vel_y),
    .len (box_width), .margin (sphint_pkg::MARGIN_XY),
    .stiffness (wall_stiffness), .damping (wall_damping), .wall (wall_y)
  );

  sphint_walls u_walls_z (
    .clk (clk), .pos (dly[LAT-4].pos_z), .half_vel (dly[LAT-4].half_vel_z),
    .len (box_height), .margin (sphint_pkg::MARGIN_Z),
    .stiffness (wall_stiffness), .damping (wall_damping), .wall (wall_z)
  );

  sphint_integ u_integ_x (
    .clk (clk), .rst (rst), .in_valid (lim_valid), .acc ($signed(lim_acc[0])),
    .wall (wall_x), .pos (dly[LAT-1].pos_x), .vel (dly[LAT-1].vel_x),
    .dt (time_step), .len (box_length), .grav (32'sd0),
    .out_valid (done), .out (res_x)
  );

  sphint_integ u_integ_y (
    .clk (clk), .rst (rst), .in_valid (lim_valid), .acc ($signed(lim_acc[1])),
    .wall (wall_y), .pos (dly[LAT-1].pos_y), .vel (dly[LAT-1].vel_y),
    .dt (time_step), .len (box_width), .grav (32'sd0),
    .out_valid (done_y), .out (res_y)
  );

  sphint_integ u_integ_z (
    .clk (clk), .rst (rst), .in_valid (lim_valid), .acc ($signed(lim_acc[2])),
    .wall (wall_z), .pos (dly[LAT-1].pos_z), .vel (dly[LAT-1].vel_z),
    .dt (time_step), .len (box_height), .grav (gravity_z),
    .out_valid (done_z), .out (res_z)
  );

  always_comb begin
    result.new_pos_x = res_x.pos;
    result.new_pos_y = res_y.pos;
    result.new_pos_z = res_z.pos;
    result.new_vel_x = res_x.vel;
    result.new_vel_y = res_y.vel;
    result.new_vel_z = res_z.vel;
    result.new_half_vel_x = res_x.half;
    result.new_half_vel_y = res_y.half;
    result.new_half_vel_z = res_z.half;
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (done == done_y) && (done == done_z))
    else $error("Axis lanes out of step.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, sphint_pkg::TOTAL_LAT))
    else $error("Result without a matching item.");

endmodule
